[rtl/gn3d_pkg.sv]
package gn3d_pkg;

  localparam int FracBitsDef = 16;
  localparam int CoordW = 32;
  localparam int OutW = 16;

  function automatic logic [7:0] perm(input logic [7:0] i);
    logic [7:0] t [256];
    t = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
      8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
      8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
      8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
      8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
      8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
      8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230,
      8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
      8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187,
      8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
      8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
      8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42,
      8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
      8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,
      8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
      8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176,
      8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66,
      8'd215, 8'd61, 8'd156, 8'd180};
    return t[i];
  endfunction

endpackage

[rtl/gn3d_fade.sv]
// quintic fade, five register stages: square, then cube and t*(15-6t), then 10 minus that, then product, then clamp
module gn3d_fade #(
  parameter int FRAC_BITS = gn3d_pkg::FracBitsDef
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t_in,
  output logic [FRAC_BITS:0]   f_out
);
  localparam int FW = FRAC_BITS;
  localparam int TW = FW + 5;
  localparam logic [2*TW-1:0] Half = (2*TW)'(1) << (FW - 1);
  localparam logic signed [TW-1:0] Fifteen = TW'(15) << FW;
  localparam logic signed [TW-1:0] Ten = TW'(10) << FW;
  localparam logic [FW:0] Unit = (FW+1)'(1) << FW;

  logic [FW-1:0] t1_r;
  logic [FW:0]   sq_r, cube_r, cube_d_r;
  logic signed [TW-1:0] c_r, d_r;
  logic [TW-1:0] fq_r;
  logic [FW:0] f_r;

  logic [2*TW-1:0] p_sq, p_cube, p_c;
  logic signed [2*TW-1:0] p_f;
  logic signed [TW-1:0] m6;
  logic [TW-1:0] fq;

  always_comb begin
    p_sq = (2*TW)'(t_in) * (2*TW)'(t_in) + Half;
    p_cube = (2*TW)'(sq_r) * (2*TW)'(t1_r) + Half;
    m6 = Fifteen - TW'(6) * TW'(t1_r);
    p_c = (2*TW)'($unsigned(m6)) * (2*TW)'(t1_r) + Half;
    p_f = $signed((2*TW)'(cube_d_r)) * (2*TW)'(d_r) + $signed(Half);
    fq = TW'($unsigned(p_f >>> FW));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_in;
      sq_r <= (FW+1)'(p_sq >> FW);
      cube_r <= (FW+1)'(p_cube >> FW);
      c_r <= TW'(p_c >> FW);
      cube_d_r <= cube_r;
      d_r <= Ten - c_r;
      fq_r <= fq;
      f_r <= (fq_r > TW'(Unit)) ? Unit : (FW+1)'(fq_r);
    end
  end

  assign f_out = f_r;
endmodule

[rtl/gn3d_hash.sv]
// lattice hashing, three rom levels, one register stage each
module gn3d_hash (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] gx,
  input  logic [7:0] gy,
  input  logic [7:0] gz,
  output logic [3:0] h_out [8]
);
  logic [7:0] a_r, b_r, gz1_r;
  logic [7:0] aa_r, ab_r, ba_r, bb_r;
  logic [3:0] h_r [8];
  logic [7:0] idx [8];
  logic [7:0] hp [8];

  always_comb begin
    idx[0] = aa_r; idx[1] = ba_r; idx[2] = ab_r; idx[3] = bb_r;
    idx[4] = aa_r + 8'd1; idx[5] = ba_r + 8'd1; idx[6] = ab_r + 8'd1; idx[7] = bb_r + 8'd1;
    for (int i = 0; i < 8; i++) hp[i] = gn3d_pkg::perm(idx[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= gn3d_pkg::perm(gx) + gy;
      b_r <= gn3d_pkg::perm(gx + 8'd1) + gy;
      gz1_r <= gz;
      aa_r <= gn3d_pkg::perm(a_r) + gz1_r;
      ab_r <= gn3d_pkg::perm(a_r + 8'd1) + gz1_r;
      ba_r <= gn3d_pkg::perm(b_r) + gz1_r;
      bb_r <= gn3d_pkg::perm(b_r + 8'd1) + gz1_r;
      for (int i = 0; i < 8; i++) h_r[i] <= hp[i][3:0];
    end
  end

  assign h_out = h_r;
endmodule

[rtl/gn3d_blend.sv]
// gradient dots and seven lerps over three levels, then output mapping
module gn3d_blend #(
  parameter int FRAC_BITS = gn3d_pkg::FracBitsDef
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [3:0]           h [8],
  input  logic [FRAC_BITS-1:0] fx,
  input  logic [FRAC_BITS-1:0] fy,
  input  logic [FRAC_BITS-1:0] fz,
  input  logic [FRAC_BITS:0]   u,
  input  logic [FRAC_BITS:0]   v,
  input  logic [FRAC_BITS:0]   w,
  output logic [15:0]          q_out
);
  localparam int FW = FRAC_BITS;
  localparam int VW = FW + 4;
  localparam int PW = 2 * VW + 2;
  localparam logic signed [VW-1:0] Unit = VW'(1) << FW;
  localparam logic signed [PW-1:0] Half = PW'(1) << (FW - 1);

  function automatic logic signed [VW-1:0] gdot(input logic [3:0] hv,
    input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
    input logic signed [VW-1:0] z);
    logic signed [VW-1:0] a, b;
    a = (hv < 4'd8) ? x : y;
    b = (hv < 4'd4) ? y : ((hv == 4'd12 || hv == 4'd14) ? x : z);
    if (hv[0]) a = -a;
    if (hv[1]) b = -b;
    return a + b;
  endfunction

  function automatic logic signed [VW-1:0] lerp(input logic [FW:0] wt,
    input logic signed [VW-1:0] a, input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p, r;
    p = $signed(PW'(wt)) * (PW'(b) - PW'(a));
    if (p >= 0) r = (p + Half) >>> FW;
    else r = -((-p + Half) >>> FW);
    return a + VW'(r);
  endfunction

  logic signed [VW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [VW-1:0] g_r [8];
  logic signed [VW-1:0] l1_r [4];
  logic signed [VW-1:0] l2_r [2];
  logic signed [VW-1:0] n_r;
  logic [FW:0] v1_r, w1_r, w2_r;
  logic [15:0] q_r;
  logic signed [VW-1:0] s;
  logic [VW+15:0] qw;

  always_comb begin
    x0 = VW'(fx); y0 = VW'(fy); z0 = VW'(fz);
    x1 = x0 - Unit; y1 = y0 - Unit; z1 = z0 - Unit;
    s = n_r + Unit;
    qw = ((VW+16)'($unsigned(s)) << 15) + ((VW+16)'(1) << (FW - 1));
    qw = qw >> FW;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[0] <= gdot(h[0], x0, y0, z0); g_r[1] <= gdot(h[1], x1, y0, z0);
      g_r[2] <= gdot(h[2], x0, y1, z0); g_r[3] <= gdot(h[3], x1, y1, z0);
      g_r[4] <= gdot(h[4], x0, y0, z1); g_r[5] <= gdot(h[5], x1, y0, z1);
      g_r[6] <= gdot(h[6], x0, y1, z1); g_r[7] <= gdot(h[7], x1, y1, z1);
      v1_r <= v; w1_r <= w; w2_r <= w1_r;
      for (int i = 0; i < 4; i++) l1_r[i] <= lerp(u, g_r[2*i], g_r[2*i+1]);
      l2_r[0] <= lerp(v1_r, l1_r[0], l1_r[1]);
      l2_r[1] <= lerp(v1_r, l1_r[2], l1_r[3]);
      n_r <= lerp(w2_r, l2_r[0], l2_r[1]);
      if (s <= 0) q_r <= '0;
      else if (qw > (VW+16)'(16'hFFFF)) q_r <= 16'hFFFF;
      else q_r <= qw[15:0];
    end
  end

  assign q_out = q_r;
endmodule

[rtl/gradient_noise_3d_top.sv]
// 3d improved gradient noise, one point per transaction. a transaction is taken
// on every cycle with start high; busy is never raised. the result appears on
// out_noise_value with out_valid high for one cycle, and the receiver cannot
// stall it. the pipeline is made of the fade pipeline (5 stages) and hash rom
// levels (run in parallel, padded to 5) followed by dot, three lerp levels and
// output mapping, each one register stage.
module gradient_noise_3d_top #(
  parameter int FRAC_BITS = gn3d_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  output logic        out_valid,
  output logic [15:0] out_noise_value
);
  localparam int Lat = 10;
  localparam int FW = FRAC_BITS;

  // alignment of fractions to the fade output (5 stages) and hash (3 stages)
  logic [FW-1:0] fx_r [5], fy_r [5], fz_r [5];
  logic [3:0] h [8];
  logic [3:0] hd_r [2][8];
  logic [FW:0] u, v, w;
  logic [Lat-1:0] vld_r;
  // fade results wait one stage for the dot products
  logic [FW:0] u_d_r, v_d_r, w_d_r;

  assign busy = 1'b0;

  gn3d_fade #(.FRAC_BITS(FW)) u_fx (.clk, .en(1'b1), .t_in(in_coord_x[FW-1:0]), .f_out(u));
  gn3d_fade #(.FRAC_BITS(FW)) u_fy (.clk, .en(1'b1), .t_in(in_coord_y[FW-1:0]), .f_out(v));
  gn3d_fade #(.FRAC_BITS(FW)) u_fz (.clk, .en(1'b1), .t_in(in_coord_z[FW-1:0]), .f_out(w));

  gn3d_hash u_hash (.clk, .en(1'b1), .gx(in_coord_x[FW+7:FW]), .gy(in_coord_y[FW+7:FW]),
    .gz(in_coord_z[FW+7:FW]), .h_out(h));

  always_ff @(posedge clk) begin
    fx_r[0] <= in_coord_x[FW-1:0]; fy_r[0] <= in_coord_y[FW-1:0];
    fz_r[0] <= in_coord_z[FW-1:0];
    for (int i = 1; i < 5; i++) begin
      fx_r[i] <= fx_r[i-1]; fy_r[i] <= fy_r[i-1]; fz_r[i] <= fz_r[i-1];
    end
    hd_r[0] <= h; hd_r[1] <= hd_r[0];
  end

  // valid bit travels alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-2:0], start};
  end

  // blend gets hashes delayed through hd_r to match fade at stage 5; u is used at the first lerp level
  gn3d_blend #(.FRAC_BITS(FW)) u_blend (.clk, .en(1'b1), .h(hd_r[1]),
    .fx(fx_r[4]), .fy(fy_r[4]), .fz(fz_r[4]),
    .u(u_d_r), .v(v_d_r), .w(w_d_r), .q_out(out_noise_value));

  always_ff @(posedge clk) begin
    u_d_r <= u; v_d_r <= v; w_d_r <= w;
  end

  assign out_valid = vld_r[Lat-1];
endmodule
